/* sv/edt_pkg.sv */
// Package with constants, types and the CORDIC angle table of the texel lookup.
package edt_pkg;

  localparam int unsigned MaxWidth    = 8192;
  localparam int unsigned MaxHeight   = 4096;
  localparam int unsigned DirFracBits = 15;
  localparam int unsigned AngleBits   = 16;
  localparam int unsigned Stages      = 32;
  // Datapath width of the CORDIC x/y registers (value up to about 2^32 * 1.65).
  localparam int unsigned XyW         = 36;
  localparam int unsigned AccW        = 34;
  localparam int unsigned SqW         = 16;

  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  // Data handed from one CORDIC cell to the next.
  typedef struct packed {
    logic               vld;
    logic signed [XyW-1:0]  ux;
    logic signed [XyW-1:0]  uy;
    logic signed [AccW-1:0] uacc;
    logic signed [XyW-1:0]  vx;
    logic signed [XyW-1:0]  vy;
    logic signed [AccW-1:0] vacc;
  } cordic_t;

  // Square-root cell payload: radicand remainder, partial root, y clamp, x and z.
  typedef struct packed {
    logic               vld;
    logic [31:0]        rem;
    logic [SqW-1:0]     root;
    logic signed [16:0] yc;
    logic signed [15:0] x;
    logic signed [15:0] z;
  } sqrt_t;

  function automatic logic [31:0] turn_angle(input logic [4:0] i);
    logic [31:0] t;
    case (i)
      5'd0:  t = 32'd536870912;  5'd1:  t = 32'd316933406;
      5'd2:  t = 32'd167458907;  5'd3:  t = 32'd85004756;
      5'd4:  t = 32'd42667331;   5'd5:  t = 32'd21354465;
      5'd6:  t = 32'd10679838;   5'd7:  t = 32'd5340245;
      5'd8:  t = 32'd2670163;    5'd9:  t = 32'd1335087;
      5'd10: t = 32'd667544;     5'd11: t = 32'd333772;
      5'd12: t = 32'd166886;     5'd13: t = 32'd83443;
      5'd14: t = 32'd41722;      5'd15: t = 32'd20861;
      5'd16: t = 32'd10430;      5'd17: t = 32'd5215;
      5'd18: t = 32'd2608;       5'd19: t = 32'd1304;
      5'd20: t = 32'd652;        5'd21: t = 32'd326;
      5'd22: t = 32'd163;        5'd23: t = 32'd81;
      5'd24: t = 32'd41;         5'd25: t = 32'd20;
      5'd26: t = 32'd10;         5'd27: t = 32'd5;
      5'd28: t = 32'd3;          5'd29: t = 32'd1;
      5'd30: t = 32'd1;          default: t = 32'd0;
    endcase
    return t;
  endfunction

endpackage

/* sv/edt_sqrt_cell.sv */
// One digit cell of the pipelined integer square root of one minus y squared.
module edt_sqrt_cell
  import edt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic [4:0]  bit_pos,
  input  sqrt_t       d_in,
  output sqrt_t       d_out
);

  sqrt_t       d_r, d_nxt;
  logic [31:0] trial;
  logic [31:0] root_ext;

  // Restoring digit step: try root bit bit_pos (weight 2^(2*bit_pos) on squares).
  always_comb begin
    root_ext = {{(32-SqW){1'b0}}, d_in.root};
    trial    = (root_ext << (bit_pos + 5'd1)) + (32'd1 << {bit_pos, 1'b0});
    d_nxt    = d_in;
    if (d_in.rem >= trial) begin
      d_nxt.rem  = d_in.rem - trial;
      d_nxt.root = d_in.root | (SqW'(1) << bit_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

/* sv/edt_cordic_cell.sv */
// One vectoring CORDIC cell that rotates both the longitude and colatitude vectors.
module edt_cordic_cell
  import edt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic [4:0]  stage,
  input  cordic_t     c_in,
  output cordic_t     c_out
);

  cordic_t          c_r, c_nxt;
  logic [AccW-1:0]  t;

  always_comb begin
    t     = AccW'(turn_angle(stage));
    c_nxt = c_in;
    // Longitude vector: drive y toward zero.
    if (c_in.uy > 0) begin
      c_nxt.ux   = c_in.ux + (c_in.uy >>> stage);
      c_nxt.uy   = c_in.uy - (c_in.ux >>> stage);
      c_nxt.uacc = c_in.uacc + $signed(t);
    end else if (c_in.uy < 0) begin
      c_nxt.ux   = c_in.ux - (c_in.uy >>> stage);
      c_nxt.uy   = c_in.uy + (c_in.ux >>> stage);
      c_nxt.uacc = c_in.uacc - $signed(t);
    end
    // Colatitude vector.
    if (c_in.vy > 0) begin
      c_nxt.vx   = c_in.vx + (c_in.vy >>> stage);
      c_nxt.vy   = c_in.vy - (c_in.vx >>> stage);
      c_nxt.vacc = c_in.vacc + $signed(t);
    end else if (c_in.vy < 0) begin
      c_nxt.vx   = c_in.vx - (c_in.vy >>> stage);
      c_nxt.vy   = c_in.vy + (c_in.vx >>> stage);
      c_nxt.vacc = c_in.vacc - $signed(t);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.vld <= 1'b0;
    end else if (en) begin
      c_r <= c_nxt;
    end
  end

  assign c_out = c_r;

endmodule

/* sv/equirect_direction_to_texel.sv */
// Top level of the equirectangular direction to texel lookup.
// Each direction passes a row of 16 square-root cells and 32 CORDIC cells, then
// five output stages (angle rounding, scaling multiplies, index, offset, output):
// 53 register stages in all. One direction is taken every cycle while the row
// is not stalled. The whole row advances together; when the output register
// holds an untaken result, the row stalls. Width and height are read at the
// scaling and index stages, so write them only while the block is idle.
module equirect_direction_to_texel
  import edt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [13:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // dir_x, dir_y, dir_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // texel_column, texel_row, texel_index, word_offset, pad
);

  localparam int unsigned Scale = 31 - DirFracBits;
  localparam int unsigned Sh    = 32 - AngleBits;
  localparam logic [16:0] One   = 17'(1 << DirFracBits);

  logic [13:0] map_width_r;
  logic [12:0] map_height_r;
  logic [13:0] w_eff;
  logic [12:0] h_eff;
  logic        en;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= 14'd1024;
      map_height_r <= 13'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        RegWidth:  map_width_r  <= cfg_wdata;
        RegHeight: map_height_r <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = (map_width_r == 14'd0) ? 14'd1 :
            (map_width_r > 14'(MaxWidth)) ? 14'(MaxWidth) : map_width_r;
    h_eff = (map_height_r == 13'd0) ? 13'd1 :
            (map_height_r > 13'(MaxHeight)) ? 13'(MaxHeight) : map_height_r;
  end

  // Output register frees the row whenever it is empty or being taken.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Clamp y and start the square root.
  sqrt_t              sq [0:SqW];
  logic signed [15:0] ix, iy, iz;
  logic signed [16:0] yc;
  logic [33:0]        ysq;

  always_comb begin
    ix = in_tdata[15:0];
    iy = in_tdata[31:16];
    iz = in_tdata[47:32];
    yc = {iy[15], iy};
    if (yc > $signed(One))  yc = $signed(One);
    if (yc < -$signed(One)) yc = -$signed(One);
    ysq = 34'($signed(yc) * $signed(yc));
    sq[0].vld  = in_tvalid;
    sq[0].rem  = 32'((34'(One) * 34'(One)) - ysq);
    sq[0].root = '0;
    sq[0].yc   = yc;
    sq[0].x    = ix;
    sq[0].z    = iz;
  end

  for (genvar g = 0; g < SqW; g++) begin : g_sqrt
    edt_sqrt_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .bit_pos(5'(SqW - 1 - g)), .d_in(sq[g]), .d_out(sq[g+1])
    );
  end

  // Quadrant pre-rotation of both vectors.
  cordic_t cc [0:Stages];
  logic signed [XyW-1:0] ux0, uy0, vx0, vy0;

  always_comb begin
    ux0 = -(XyW'(sq[SqW].x) <<< Scale);
    uy0 = -(XyW'(sq[SqW].z) <<< Scale);
    vx0 = XyW'(sq[SqW].yc) <<< Scale;
    vy0 = XyW'({1'b0, sq[SqW].root}) <<< Scale;
    cc[0].vld  = sq[SqW].vld;
    cc[0].ux   = ux0;
    cc[0].uy   = uy0;
    cc[0].uacc = '0;
    if (ux0 < 0) begin
      cc[0].ux   = -ux0;
      cc[0].uy   = -uy0;
      cc[0].uacc = (uy0 >= 0) ? AccW'(64'sd2147483648) : -AccW'(64'sd2147483648);
    end
    cc[0].vx   = vx0;
    cc[0].vy   = vy0;
    cc[0].vacc = '0;
    if (vx0 < 0) begin
      cc[0].vx   = -vx0;
      cc[0].vy   = -vy0;
      cc[0].vacc = (vy0 >= 0) ? AccW'(64'sd2147483648) : -AccW'(64'sd2147483648);
    end
  end

  for (genvar g = 0; g < Stages; g++) begin : g_cordic
    edt_cordic_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .stage(5'(g)), .c_in(cc[g]), .c_out(cc[g+1])
    );
  end

  // Stage 1: round angles to turn fractions.
  logic                 s1_vld_r;
  logic [AngleBits-1:0] u_r;
  logic [AngleBits:0]   v_r;
  logic [31:0]          ua_mod;
  logic [AccW-1:0]      va_cl;
  logic [32:0]          ua_rnd;
  logic [33:0]          va_rnd;

  always_comb begin
    ua_mod = cc[Stages].uacc[31:0];
    ua_rnd = {1'b0, ua_mod} + 33'(1 << (Sh - 1));
    va_cl  = cc[Stages].vacc;
    if (cc[Stages].vacc < 0) va_cl = '0;
    if ($signed(cc[Stages].vacc) > $signed(AccW'(64'sd2147483648)))
      va_cl = AccW'(64'sd2147483648);
    va_rnd = {va_cl[32:0], 1'b0} + 34'(1 << (Sh - 1));
  end

  // Stages 2 to 5: scale, index, offset, output.
  logic        s2_vld_r, s3_vld_r, s4_vld_r;
  logic [12:0] col2_r, col3_r, col4_r;
  logic [11:0] row2_r, row3_r, row4_r;
  logic [29:0] ucol;
  logic [29:0] vrow;
  logic [24:0] idx3_r, idx4_r;
  logic [26:0] off4_r;

  always_comb begin
    ucol = 30'(u_r) * 30'(w_eff - 14'd1);
    vrow = 30'(v_r) * 30'(h_eff - 13'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      s3_vld_r   <= 1'b0;
      s4_vld_r   <= 1'b0;
      out_tvalid <= 1'b0;
    end else if (en) begin
      s1_vld_r   <= cc[Stages].vld;
      s2_vld_r   <= s1_vld_r;
      s3_vld_r   <= s2_vld_r;
      s4_vld_r   <= s3_vld_r;
      out_tvalid <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r    <= ua_rnd[31:Sh];
      v_r    <= va_rnd[32:Sh];
      col2_r <= ucol[28:AngleBits];
      row2_r <= vrow[27:AngleBits];
      col3_r <= col2_r;
      row3_r <= row2_r;
      idx3_r <= 25'(25'(row2_r) * 25'(w_eff) + 25'(col2_r));
      col4_r <= col3_r;
      row4_r <= row3_r;
      idx4_r <= idx3_r;
      off4_r <= 27'({idx3_r, 1'b0}) + 27'(idx3_r);
      out_tdata <= {3'b000, off4_r, idx4_r, row4_r, col4_r};
    end
  end

endmodule

/* sim/tb.sv */
// Testbench for the equirectangular direction to texel lookup, self-checking.
module tb;
  import edt_pkg::*;

  // One expected texel result.
  typedef struct packed {
    logic [12:0] column;
    logic [11:0] row;
    logic [24:0] index;
    logic [26:0] offset;
  } texel_t;

  // One row of the directed stimulus table.
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    bit                 typed;
    texel_t             want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [13:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // dir_x, dir_y, dir_z
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;  // texel_column, texel_row, texel_index, word_offset, pad

  texel_t      pending_texels[$];
  logic [13:0] width_reg;
  logic [12:0] height_reg;
  int          err_count;
  int          quiet_cycles;
  bit          steady;
  int          rx_hold;

  longint turn_steps[32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};

  equirect_direction_to_texel DUT (.*);

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Vectoring rotation: angle of (x, y) in 2^-32 turn.
  function automatic longint turn_angle_of(input longint x, input longint y);
    longint acc;
    longint dx;
    longint dy;
    acc = 0;
    if (x < 0) begin
      acc = (y >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        acc += turn_steps[i];
      end else if (y < 0) begin
        x -= dx;
        y += dy;
        acc -= turn_steps[i];
      end
    end
    return acc;
  endfunction

  // Expected texel for one direction under the current width and height.
  function automatic texel_t lookup_texel(input logic signed [15:0] dx,
                                          input logic signed [15:0] dy,
                                          input logic signed [15:0] dz);
    longint one;
    longint yc;
    longint n;
    longint s;
    longint a;
    longint u;
    longint v;
    longint w;
    longint h;
    longint col;
    longint row;
    longint idx;
    texel_t t;
    one = 64'sd1 <<< DirFracBits;
    w = (width_reg == 0) ? 1 : (width_reg > MaxWidth) ? MaxWidth : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > MaxHeight) ? MaxHeight : height_reg;
    a = turn_angle_of(-longint'(dx) * 65536, -longint'(dz) * 65536);
    u = (((a & 64'hFFFF_FFFF) + 64'h8000) >> 16) & 64'hFFFF;
    yc = dy;
    if (yc > one) yc = one;
    if (yc < -one) yc = -one;
    n = one * one - yc * yc;
    s = 0;
    for (int b = 15; b >= 0; b--) begin
      if ((s | (64'sd1 <<< b)) * (s | (64'sd1 <<< b)) <= n) s = s | (64'sd1 <<< b);
    end
    a = turn_angle_of(yc * 65536, s * 65536);
    if (a < 0) a = 0;
    if (a > (64'sd1 <<< 31)) a = 64'sd1 <<< 31;
    v = (a * 2 + 64'h8000) >> 16;
    col = (u * (w - 1)) >> 16;
    row = (v * (h - 1)) >> 16;
    idx = row * w + col;
    t.column = col[12:0];
    t.row    = row[11:0];
    t.index  = idx[24:0];
    t.offset = 27'(idx * 3);
    return t;
  endfunction

  // Offer one direction, with a random gap unless steady, and record its expectation on transfer.
  task automatic send_dir(input logic signed [15:0] x, input logic signed [15:0] y,
                          input logic signed [15:0] z, input bit typed, input texel_t want);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_texels.push_back(typed ? want : lookup_texel(x, y, z));
  endtask

  // Drain the block, then write both registers.
  task automatic set_map(input logic [13:0] w, input logic [13:0] h);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_texels.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= RegWidth;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= RegHeight;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
    width_reg  = w;
    height_reg = h[12:0];
  endtask

  // Random direction, weighted toward the special cases.
  task automatic send_random_dir();
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    texel_t none;
    none = '0;
    x = 16'($urandom);
    y = 16'($urandom);
    z = 16'($urandom);
    case ($urandom_range(0, 9))
      6: y = ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7FFF;
      7: begin
        x = 0;
        z = 0;
      end
      8: begin
        x = 16'($signed($urandom_range(0, 8)) - 4);
        z = 16'($signed($urandom_range(0, 8)) - 4);
      end
      9: x = ($urandom_range(0, 1) != 0) ? 16'sh8001 : 16'sh7FFF;
      default: ;
    endcase
    send_dir(x, y, z, 1'b0, none);
  endtask

  // Result side: check each transfer and draw a stall for the next one.
  always @(posedge clk) begin
    texel_t got;
    texel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.column = out_tdata[12:0];
      got.row    = out_tdata[24:13];
      got.index  = out_tdata[49:25];
      got.offset = out_tdata[76:50];
      if (pending_texels.size() == 0) begin
        $error("unexpected result transfer %h", out_tdata);
        err_count++;
      end else begin
        want = pending_texels.pop_front();
        if (got.column !== want.column) begin
          $error("texel_column expected %0d got %0d", want.column, got.column);
          err_count++;
        end
        if (got.row !== want.row) begin
          $error("texel_row expected %0d got %0d", want.row, got.row);
          err_count++;
        end
        if (got.index !== want.index) begin
          $error("texel_index expected %0d got %0d", want.index, got.index);
          err_count++;
        end
        if (got.offset !== want.offset) begin
          $error("word_offset expected %0d got %0d", want.offset, got.offset);
          err_count++;
        end
      end
      rx_hold = steady ? 0 : $urandom_range(0, 4);
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= 5000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Main sequence: directed table, then random phases over several map sizes.
  initial begin
    dir_row_t table_rows[$];
    dir_row_t r;
    texel_t none;
    logic [13:0] widths[6];
    logic [13:0] heights[6];
    none = '0;
    err_count = 0;
    quiet_cycles = 0;
    steady = 1'b0;
    rx_hold = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = RegWidth;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    width_reg = 14'd1024;
    height_reg = 13'd512;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Straight down (y at minus one) lands on the last row, column zero.
    table_rows.push_back('{0, -32768, 0, 1'b1, '{13'd0, 12'd511, 25'd523264, 27'd1569792}});
    table_rows.push_back('{0, 32767, 0, 1'b0, none});
    table_rows.push_back('{0, 0, 0, 1'b0, none});
    table_rows.push_back('{32767, 0, 0, 1'b0, none});
    table_rows.push_back('{-32768, 0, 0, 1'b0, none});
    table_rows.push_back('{0, 0, 32767, 1'b0, none});
    table_rows.push_back('{0, 0, -32768, 1'b0, none});
    table_rows.push_back('{-32768, 0, 1, 1'b0, none});
    table_rows.push_back('{-32768, 0, -1, 1'b0, none});
    table_rows.push_back('{-1, 0, -1, 1'b0, none});
    table_rows.push_back('{1, 0, 1, 1'b0, none});
    table_rows.push_back('{23170, 0, -23170, 1'b0, none});
    table_rows.push_back('{-32768, -32768, -32768, 1'b0, none});
    table_rows.push_back('{32767, 32767, 32767, 1'b0, none});
    table_rows.push_back('{-1, -1, -1, 1'b0, none});
    @(posedge clk);
    foreach (table_rows[i]) begin
      r = table_rows[i];
      send_dir(r.x, r.y, r.z, r.typed, r.want);
    end

    widths  = '{14'd1, 14'd0, 14'd8192, 14'd16383, 14'd1024, 14'd0};
    heights = '{14'd1, 14'd0, 14'd4096, 14'd16383, 14'd512, 14'd0};
    widths[5]  = 14'($urandom_range(2, 8192));
    heights[5] = 14'($urandom_range(2, 4096));
    for (int p = 0; p < 6; p++) begin
      // Each map change waits for every expected result first.
      set_map(widths[p], heights[p]);
      steady = (p == 2);
      repeat (322) send_random_dir();
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending_texels.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (err_count == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule

/* equirect_direction_to_texel.f */
sv/edt_pkg.sv
sv/edt_sqrt_cell.sv
sv/edt_cordic_cell.sv
sv/equirect_direction_to_texel.sv
sim/tb.sv
